[rtl/core/lfpcf_pkg.sv]
// Package of constants and types for the lidar frame parser and change filter.
`default_nettype none

package lfpcf_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned PAYLOAD_LEN = 6;
   localparam int unsigned IDX_W      = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned RSP_DATA_W = 3 * VALUE_W;

   localparam logic [BYTE_W-1:0]  HDR_BYTE       = 8'h59;
   localparam logic [IDX_W-1:0]   CHECKSUM_INDEX = 3'd6;
   localparam logic [VALUE_W-1:0] AMP_THR_RESET  = 16'd100;
   localparam logic [VALUE_W-1:0] TEMP_THR_RESET = 16'd10;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_THR  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_THR = 1'b1;

   // Frame synchroniser phases.
   typedef enum logic [2:0] {
      PHASE_HUNT = 3'b001,
      PHASE_HDR2 = 3'b010,
      PHASE_BODY = 3'b100
   } phase_type;

endpackage

`default_nettype wire

[rtl/core/lidar_frame_parser_change_filter.sv]
// Lidar serial frame parser with checksum check and change filter.
//
// Usage: received serial bytes enter one item at a time on the req_ channel.
// The block hunts for the two header bytes 0x59 0x59, collects six payload
// bytes and a checksum byte, and checks that the checksum equals the low byte
// of the sum of the eight bytes before it. A good frame gives one item on the
// rsp_ channel (distance, amplitude, raw temperature) when no frame has been
// reported yet, the distance differs, or amplitude or temperature has moved
// by at least its threshold. A bad checksum drops the frame and hunting
// starts again. The thresholds are set through the csr_ write port while the
// block is idle.
// A checksum byte waits in the input register; its result is loaded into the
// output register once it is free. Throughput: one byte per cycle unless the
// receiver stalls, set by the single input register feeding the single output
// register. A stalled receiver holds the result in the output register; the
// input register then fills and req_tready falls until the result is taken.
// Reset (synchronous, active high) returns to header hunting, forgets the
// last reported values and restores threshold defaults of 100 and 10.
`default_nettype none

module lidar_frame_parser_change_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Byte stream in.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lfpcf_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] rx_byte
   // Reported measurements out.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [lfpcf_pkg::RSP_DATA_W-1:0]         rsp_tdata,   // [15:0] distance,
                                                                 // [31:16] amplitude,
                                                                 // [47:32] temperature_raw
   // Configuration writes.
   input  wire logic                                csr_wr_en,
   input  wire logic [lfpcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lfpcf_pkg::VALUE_W-1:0]       csr_wdata
);

   // Input register.
   logic                             in_vld_ff, in_vld_in;
   logic [lfpcf_pkg::BYTE_W-1:0]     in_byte_ff;
   logic                             out_free;
   logic                             in_take;

   // Frame state.
   lfpcf_pkg::phase_type             phase_ff, phase_in;
   logic [lfpcf_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [lfpcf_pkg::BYTE_W-1:0]     sum_ff, sum_in;
   logic [lfpcf_pkg::BYTE_W-1:0]     pay_ff [lfpcf_pkg::PAYLOAD_LEN];
   logic [lfpcf_pkg::BYTE_W-1:0]     pay_in [lfpcf_pkg::PAYLOAD_LEN];

   // Change filter state.
   logic [lfpcf_pkg::VALUE_W-1:0]    last_dist_ff, last_dist_in;
   logic [lfpcf_pkg::VALUE_W-1:0]    last_amp_ff, last_amp_in;
   logic [lfpcf_pkg::VALUE_W-1:0]    last_temp_ff, last_temp_in;
   logic                             have_last_ff, have_last_in;
   logic [lfpcf_pkg::VALUE_W-1:0]    amp_thr_ff, amp_thr_in;
   logic [lfpcf_pkg::VALUE_W-1:0]    temp_thr_ff, temp_thr_in;

   // Output register.
   logic                             rsp_vld_ff, rsp_vld_in;
   logic [lfpcf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Frame decode.
   logic [lfpcf_pkg::VALUE_W-1:0]    distance;
   logic [lfpcf_pkg::VALUE_W-1:0]    amp;
   logic [lfpcf_pkg::VALUE_W-1:0]    temp;
   logic [lfpcf_pkg::VALUE_W-1:0]    amp_diff;
   logic [lfpcf_pkg::VALUE_W-1:0]    temp_diff;
   logic                             report;
   logic                             res_load;

   // The input register drains whenever the output register can take a
   // result this cycle, whether or not the byte produces one.
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign in_take    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (in_take) begin
         in_vld_in = 1'b0;
      end
   end

   // Payload fields, little-endian pairs.
   assign distance = {pay_ff[1], pay_ff[0]};
   assign amp      = {pay_ff[3], pay_ff[2]};
   assign temp     = {pay_ff[5], pay_ff[4]};

   assign amp_diff  = (amp >= last_amp_ff) ? amp - last_amp_ff : last_amp_ff - amp;
   assign temp_diff = (temp >= last_temp_ff) ? temp - last_temp_ff : last_temp_ff - temp;

   assign report = !have_last_ff
                || (distance != last_dist_ff)
                || (amp_diff >= amp_thr_ff)
                || (temp_diff >= temp_thr_ff);

   // Sequencing of one byte through the frame synchroniser.
   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      pay_in       = pay_ff;
      res_load     = 1'b0;
      if (in_take) begin
         case (phase_ff)
            lfpcf_pkg::PHASE_HDR2: begin
               if (in_byte_ff == lfpcf_pkg::HDR_BYTE) begin
                  phase_in = lfpcf_pkg::PHASE_BODY;
                  idx_in   = '0;
                  sum_in   = lfpcf_pkg::HDR_BYTE + lfpcf_pkg::HDR_BYTE;
               end else begin
                  phase_in = lfpcf_pkg::PHASE_HUNT;
               end
            end
            lfpcf_pkg::PHASE_BODY: begin
               if (idx_ff != lfpcf_pkg::CHECKSUM_INDEX) begin
                  pay_in[idx_ff] = in_byte_ff;
                  sum_in         = sum_ff + in_byte_ff;
                  idx_in         = idx_ff + 1'b1;
               end else begin
                  // Checksum byte: the frame ends here either way.
                  phase_in = lfpcf_pkg::PHASE_HUNT;
                  idx_in   = '0;
                  res_load = (in_byte_ff == sum_ff) && report;
               end
            end
            default: begin
               // Hunting the first header byte.
               phase_in = (in_byte_ff == lfpcf_pkg::HDR_BYTE) ? lfpcf_pkg::PHASE_HDR2
                                                              : lfpcf_pkg::PHASE_HUNT;
            end
         endcase
      end
   end

   // The last reported values move only when a result is produced.
   always_comb begin
      last_dist_in = last_dist_ff;
      last_amp_in  = last_amp_ff;
      last_temp_in = last_temp_ff;
      have_last_in = have_last_ff;
      if (res_load) begin
         last_dist_in = distance;
         last_amp_in  = amp;
         last_temp_in = temp;
         have_last_in = 1'b1;
      end
   end

   always_comb begin
      amp_thr_in  = amp_thr_ff;
      temp_thr_in = temp_thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lfpcf_pkg::CSR_AMP_THR:  amp_thr_in  = csr_wdata;
            lfpcf_pkg::CSR_TEMP_THR: temp_thr_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (res_load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {temp, amp, distance};
      end else if (rsp_tready) begin
         rsp_vld_in  = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         phase_ff     <= lfpcf_pkg::PHASE_HUNT;
         idx_ff       <= '0;
         sum_ff       <= '0;
         last_dist_ff <= '0;
         last_amp_ff  <= '0;
         last_temp_ff <= '0;
         have_last_ff <= 1'b0;
         amp_thr_ff   <= lfpcf_pkg::AMP_THR_RESET;
         temp_thr_ff  <= lfpcf_pkg::TEMP_THR_RESET;
         rsp_vld_ff   <= 1'b0;
      end else begin
         in_vld_ff    <= in_vld_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         last_dist_ff <= last_dist_in;
         last_amp_ff  <= last_amp_in;
         last_temp_ff <= last_temp_in;
         have_last_ff <= have_last_in;
         amp_thr_ff   <= amp_thr_in;
         temp_thr_ff  <= temp_thr_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      pay_ff      <= pay_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A result can only come from a checksum byte in the frame body.
   a_load_on_checksum: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (phase_ff == lfpcf_pkg::PHASE_BODY)
                && (idx_ff == lfpcf_pkg::CHECKSUM_INDEX))
      else $error("result loaded outside a checksum byte");

   // The payload counter never runs past the checksum position.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= lfpcf_pkg::CHECKSUM_INDEX)
      else $error("payload index out of range");

   // A reported distance becomes the reference for the next frame.
   a_last_follows_result: assert property (@(posedge clock) disable iff (reset)
      res_load |=> have_last_ff && (last_dist_ff == rsp_data_ff[lfpcf_pkg::VALUE_W-1:0]))
      else $error("last reported distance not updated");

   // A result is never overwritten: the input register only drains into a free output.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_tready) |-> !res_load)
      else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

[tb/sv/lfpcf_measurement_checker.sv]
// Checker that predicts and compares the measurements reported by the frame parser.
`timescale 1ns / 100ps

module lfpcf_measurement_checker
   import lfpcf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [VALUE_W-1:0]    csr_wdata,
   output int                         fail_count,
   output int                         pending_count,
   output int                         match_count,
   output int                         filtered_count,
   output int                         bad_sum_count
);

   // Packed so that distance sits in the lowest bits, as on rsp_tdata.
   typedef struct packed {
      logic [VALUE_W-1:0] temperature_raw;
      logic [VALUE_W-1:0] amplitude;
      logic [VALUE_W-1:0] distance;
   } meas_type;

   meas_type           expected_meas_q[$];

   logic [VALUE_W-1:0] amp_thr;
   logic [VALUE_W-1:0] temp_thr;
   phase_type          sync_phase;
   logic [IDX_W-1:0]   payload_index;
   logic [BYTE_W-1:0]  frame_sum;
   logic [BYTE_W-1:0]  payload_mem [PAYLOAD_LEN];
   meas_type           last_meas;
   logic               have_last;

   function automatic logic [VALUE_W-1:0] value_gap(input logic [VALUE_W-1:0] a,
                                                    input logic [VALUE_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic compare_result(input meas_type got);
      meas_type want;
      if (expected_meas_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", got));
         return;
      end
      want = expected_meas_q.pop_front();
      if (got.distance !== want.distance) begin
         report_mismatch($sformatf("distance %h, wanted %h", got.distance, want.distance));
      end
      if (got.amplitude !== want.amplitude) begin
         report_mismatch($sformatf("amplitude %h, wanted %h", got.amplitude, want.amplitude));
      end
      if (got.temperature_raw !== want.temperature_raw) begin
         report_mismatch($sformatf("temperature %h, wanted %h",
                                   got.temperature_raw, want.temperature_raw));
      end
      if (got === want) begin
         match_count++;
      end
   endtask

   task automatic parse_rx_byte(input logic [BYTE_W-1:0] rx);
      meas_type frame;
      logic     changed;
      case (sync_phase)
         PHASE_HDR2: begin
            if (rx == HDR_BYTE) begin
               sync_phase    = PHASE_BODY;
               payload_index = '0;
               frame_sum     = HDR_BYTE + HDR_BYTE;
            end else begin
               sync_phase = PHASE_HUNT;
            end
         end
         PHASE_BODY: begin
            if (payload_index < CHECKSUM_INDEX) begin
               payload_mem[payload_index] = rx;
               frame_sum     = frame_sum + rx;
               payload_index = payload_index + 1'b1;
            end else begin
               sync_phase    = PHASE_HUNT;
               payload_index = '0;
               if (rx != frame_sum) begin
                  bad_sum_count++;
               end else begin
                  frame.distance        = {payload_mem[1], payload_mem[0]};
                  frame.amplitude       = {payload_mem[3], payload_mem[2]};
                  frame.temperature_raw = {payload_mem[5], payload_mem[4]};
                  changed = !have_last
                     || frame.distance != last_meas.distance
                     || value_gap(frame.amplitude, last_meas.amplitude) >= amp_thr
                     || value_gap(frame.temperature_raw, last_meas.temperature_raw) >= temp_thr;
                  if (changed) begin
                     last_meas = frame;
                     have_last = 1'b1;
                     expected_meas_q.push_back(frame);
                  end else begin
                     filtered_count++;
                  end
               end
            end
         end
         default: begin
            sync_phase = (rx == HDR_BYTE) ? PHASE_HDR2 : PHASE_HUNT;
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         amp_thr       = AMP_THR_RESET;
         temp_thr      = TEMP_THR_RESET;
         sync_phase    = PHASE_HUNT;
         payload_index = '0;
         frame_sum     = '0;
         last_meas     = '0;
         have_last     = 1'b0;
         expected_meas_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            compare_result(rsp_tdata);
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_AMP_THR:  amp_thr  = csr_wdata;
               CSR_TEMP_THR: temp_thr = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata);
         end
      end
      pending_count = expected_meas_q.size();
   end

endmodule

[tb/sv/lidar_frame_parser_change_filter_tb.sv]
// Top of the testbench for the lidar frame parser and change filter.
`timescale 1ns / 100ps

// The top only makes stimulus and gives the verdict. Serial bytes go in one
// item at a time: first a handful of directed cases (a broken header, a frame
// whose first payload byte repeats the header byte, field extremes and a bad
// checksum), then random traffic that is mostly well-formed frames with some
// noise, broken headers and corrupted checksums mixed in. The frame values
// drift around the last ones sent, so that the change filter is pushed from
// both sides of its thresholds. The run walks through five threshold settings,
// the reset defaults, both extremes and two others, and the checker beside the
// block predicts and compares every reported item.
module lidar_frame_parser_change_filter_tb;
   import lfpcf_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [VALUE_W-1:0]    csr_wdata = '0;

   int fail_count;
   int pending_count;
   int match_count;
   int filtered_count;
   int bad_sum_count;

   // Random idling on both sides; switched off for the last part of the run.
   bit idling = 1'b1;
   int stall_left = 0;
   int bytes_sent = 0;

   // Thresholds as last written, and the values of the last good frame sent.
   // The frame generator uses them to land near the filter's decision points.
   logic [VALUE_W-1:0] amp_thr_now  = AMP_THR_RESET;
   logic [VALUE_W-1:0] temp_thr_now = TEMP_THR_RESET;
   logic [VALUE_W-1:0] prev_dist    = '0;
   logic [VALUE_W-1:0] prev_amp     = '0;
   logic [VALUE_W-1:0] prev_temp    = '0;

   lidar_frame_parser_change_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lfpcf_measurement_checker meas_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .match_count    (match_count),
      .filtered_count (filtered_count),
      .bad_sum_count  (bad_sum_count)
   );

   always #1 clock = ~clock;

   // The receiver stalls in bursts of random length. Each negative edge
   // gives rsp_tready exactly one value, so the block sees it settled at the
   // next rising edge.
   always @(negedge clock) begin
      if (!idling) begin
         rsp_tready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(1, 9) - 1;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Presents one byte and holds it until it is accepted. It is entered just
   // after a falling edge and returns just after the falling edge that follows
   // the handshake, with req_tvalid still high so that the next item can
   // follow straight on.
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = rx;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Sends a whole frame: two header bytes, the three little-endian values and
   // the checksum, which is deliberately spoilt when corrupt is set.
   task automatic send_frame(input logic [VALUE_W-1:0] distance,
                             input logic [VALUE_W-1:0] amp,
                             input logic [VALUE_W-1:0] temp,
                             input bit                 corrupt);
      logic [BYTE_W-1:0] frame_bytes [9];
      logic [BYTE_W-1:0] check;
      frame_bytes = '{HDR_BYTE, HDR_BYTE, distance[7:0], distance[15:8],
                      amp[7:0], amp[15:8], temp[7:0], temp[15:8], 8'h00};
      check = '0;
      for (int i = 0; i < 8; i++) begin
         check = check + frame_bytes[i];
      end
      if (corrupt) begin
         check = check ^ BYTE_W'($urandom_range(1, 255));
      end else begin
         prev_dist = distance;
         prev_amp  = amp;
         prev_temp = temp;
      end
      frame_bytes[8] = check;
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i]);
      end
   endtask

   // Picks a value close to base: equal, just inside or just outside the
   // threshold, with now and then a wholly random value or an extreme.
   function automatic logic [VALUE_W-1:0] drift_value(input logic [VALUE_W-1:0] base,
                                                      input int unsigned        thr);
      int unsigned step;
      step = $urandom_range(0, thr + 2);
      case ($urandom_range(0, 5))
         0:       return base;
         1:       return VALUE_W'($urandom);
         2:       return $urandom_range(0, 1) ? {VALUE_W{1'b1}} : '0;
         3:       return base - VALUE_W'(step);
         default: return base + VALUE_W'(step);
      endcase
   endfunction

   // Brings the block to rest: the byte stream stops, every expected item is
   // collected, and a few more cycles pass in case a dropped frame is still
   // on its way through the input register.
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Writes both thresholds back to back while the block is at rest.
   task automatic set_thresholds(input logic [VALUE_W-1:0] amp_thr,
                                 input logic [VALUE_W-1:0] temp_thr);
      settle();
      csr_wr_en = 1'b1;
      csr_index = CSR_AMP_THR;
      csr_wdata = amp_thr;
      @(negedge clock);
      csr_index = CSR_TEMP_THR;
      csr_wdata = temp_thr;
      @(negedge clock);
      csr_wr_en    = 1'b0;
      amp_thr_now  = amp_thr;
      temp_thr_now = temp_thr;
   endtask

   // Mostly well-formed frames with drifting content; the rest is noise,
   // broken headers and frames with a bad checksum.
   task automatic random_traffic(input int byte_target);
      int                 pick;
      logic [VALUE_W-1:0] next_dist;
      while (bytes_sent < byte_target) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_byte($urandom_range(0, 3) == 0 ? HDR_BYTE : BYTE_W'($urandom));
            end
         end else if (pick == 1) begin
            send_byte(HDR_BYTE);
            send_byte(BYTE_W'($urandom_range(0, HDR_BYTE - 1)));
         end else begin
            next_dist = $urandom_range(0, 1) ? prev_dist : drift_value(prev_dist, 2);
            send_frame(next_dist, drift_value(prev_amp, amp_thr_now),
                       drift_value(prev_temp, temp_thr_now), $urandom_range(0, 6) == 0);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset thresholds. A broken header is followed by
      // a frame whose first payload byte equals the header byte, so the third
      // 0x59 in a row must be taken as payload; then a frame with a bad
      // checksum at the opposite field extremes.
      send_byte(HDR_BYTE);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_frame(16'hFF59, 16'hFFFF, 16'h0000, 1'b0);
      send_frame(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
      random_traffic(130);

      // A threshold of zero lets every good frame through.
      set_thresholds('0, '0);
      random_traffic(260);

      // The largest thresholds: only a distance change or a full-range swing can make a report.
      set_thresholds('1, '1);
      random_traffic(390);

      set_thresholds(VALUE_W'($urandom_range(1, 300)), VALUE_W'($urandom_range(1, 40)));
      random_traffic(520);

      // The last part runs with no idling on either side.
      idling = 1'b0;
      set_thresholds(16'd1, 16'd1);
      random_traffic(650);

      settle();
      $display("Sent %0d serial bytes across five threshold settings, extremes included.",
               bytes_sent);
      $display("Reports matched: %0d, frames held back by the filter: %0d, bad checksums: %0d.",
               match_count, filtered_count, bad_sum_count);
      if (fail_count == 0) begin
         $display("[lidar_frame_parser_change_filter] OK");
      end else begin
         $display("[lidar_frame_parser_change_filter] ERROR");
      end
      $finish;
   end

   // A generous ceiling, far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Timed out with %0d items still expected.", pending_count);
      $display("[lidar_frame_parser_change_filter] ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/core/lfpcf_pkg.sv
rtl/core/lidar_frame_parser_change_filter.sv
tb/sv/lfpcf_measurement_checker.sv
tb/sv/lidar_frame_parser_change_filter_tb.sv
